// ----- rtl/nnp_pkg.sv -----
// shared types, widths and codes for the nearest neighbor pairing block
package nnp_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_W    = 24;
  localparam int DIST_W     = 51;

  localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int EXT_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W + 1;

  localparam int IN_DATA_W   = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + 2 * COORD_W + 4 + 2 * COORD_W + DIST_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  localparam logic [1:0] REG_OFFSET_X  = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic rotate;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
    coord_t           px;
    coord_t           py;
  } scan_item_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
    coord_t           px;
    coord_t           py;
    dist_t            dsq;
  } dist_res_t;

endpackage

// ----- rtl/nnp_cell.sv -----
// one storage cell of the point ring: holds one stored point
module nnp_cell (
  input  logic               clk,
  input  nnp_pkg::cell_ctl_t ctl,
  input  nnp_pkg::coord_t    wr_x,
  input  nnp_pkg::coord_t    wr_y,
  input  nnp_pkg::coord_t    nb_x,
  input  nnp_pkg::coord_t    nb_y,
  output nnp_pkg::coord_t    x,
  output nnp_pkg::coord_t    y
);
  import nnp_pkg::*;

  coord_t x_r;
  coord_t y_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end else if (ctl.rotate) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

// ----- rtl/nnp_dist.sv -----
// three-stage squared distance pipeline fed from the head of the ring
module nnp_dist (
  input  logic                clk,
  input  logic                rst_n,
  input  nnp_pkg::scan_item_t item,
  input  nnp_pkg::coord_t     cx,
  input  nnp_pkg::coord_t     cy,
  input  nnp_pkg::coord_t     ox,
  input  nnp_pkg::coord_t     oy,
  output nnp_pkg::dist_res_t  res
);
  import nnp_pkg::*;

  scan_item_t s1_item_r;
  logic [MAG_W-1:0] s1_mag_x_r, s1_mag_y_r;
  logic [MAG_W-1:0] mag_x_nxt, mag_y_nxt;
  scan_item_t s2_item_r;
  logic [SQ_W-1:0] s2_sq_x_r, s2_sq_y_r;
  dist_res_t s3_r;
  dist_res_t s3_nxt;

  logic signed [COORD_W+1:0] pred_x, pred_y, diff_x, diff_y, abs_x, abs_y;
  logic [SUM_W-1:0] sum;
  logic [EXT_W-1:0] sum_ext;

  // predicted position of the stored point, then magnitude of the difference
  always_comb begin
    pred_x = (COORD_W+2)'(item.px) + (COORD_W+2)'(ox);
    pred_y = (COORD_W+2)'(item.py) + (COORD_W+2)'(oy);
    diff_x = (COORD_W+2)'(cx) - pred_x;
    diff_y = (COORD_W+2)'(cy) - pred_y;
    abs_x  = diff_x[COORD_W+1] ? -diff_x : diff_x;
    abs_y  = diff_y[COORD_W+1] ? -diff_y : diff_y;
    mag_x_nxt = abs_x[MAG_W-1:0];
    mag_y_nxt = abs_y[MAG_W-1:0];
  end

  always_comb begin
    sum     = {1'b0, s2_sq_x_r} + {1'b0, s2_sq_y_r};
    sum_ext = EXT_W'(sum);
    s3_nxt.valid = s2_item_r.valid;
    s3_nxt.last  = s2_item_r.last;
    s3_nxt.idx   = s2_item_r.idx;
    s3_nxt.px    = s2_item_r.px;
    s3_nxt.py    = s2_item_r.py;
    // saturate when the sum does not fit the distance field
    s3_nxt.dsq   = (sum_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r <= '0;
      s2_item_r <= '0;
      s3_r      <= '0;
    end else begin
      s1_item_r <= item;
      s2_item_r <= s1_item_r;
      s3_r      <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag_x_r <= mag_x_nxt;
    s1_mag_y_r <= mag_y_nxt;
    s2_sq_x_r  <= {{MAG_W{1'b0}}, s1_mag_x_r} * {{MAG_W{1'b0}}, s1_mag_x_r};
    s2_sq_y_r  <= {{MAG_W{1'b0}}, s1_mag_y_r} * {{MAG_W{1'b0}}, s1_mag_y_r};
  end

  assign res = s3_r;

endmodule

// ----- rtl/nearest_neighbor_pairing.sv -----
// top level: point ring, scan sequencer, best-match tracking and registers
//
//  channel   direction  handshake                 payload
//  in_       slave      in_tvalid / in_tready     tuser func, tdata point_x, point_y
//  out_      master     out_tvalid / out_tready   tdata result word
//  cfg_      apb slave  psel, penable, pready=1   offset_x, offset_y, threshold_sq
//
// clear and load words leave the input ready for the next word; during a query
// the ring of cells rotates once past the distance pipeline,
// one stored point per cycle, then three pipeline stages drain and the result
// is registered. in_tready is low from a query until its result is in the
// output register; a stalled output holds the block in its last query state.
// synchronous active-low reset empties the store and clears the registers.
module nearest_neighbor_pairing (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // point_x, point_y
  input  logic [nnp_pkg::IN_DATA_W-1:0]       in_tdata,
  // func
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // matched, current_x, current_y, best_index, best_x, best_y, distance_sq,
  // overflow, zero pad
  output logic [nnp_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [nnp_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [nnp_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [nnp_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import nnp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic dropped_r, dropped_nxt;
  coord_t qx_r, qy_r;
  coord_t offset_x_r, offset_y_r;
  dist_t threshold_r;

  logic found_r;
  dist_t best_d_r;
  logic [IDX_W-1:0] best_idx_r;
  coord_t best_x_r, best_y_r;

  logic out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic in_acc, cfg_wr, is_load, has_room, take_best, out_free;
  logic [1:0] func, reg_sel;
  coord_t in_x, in_y;

  coord_t cell_x [MAX_POINTS];
  coord_t cell_y [MAX_POINTS];
  cell_ctl_t cell_ctl [MAX_POINTS];

  scan_item_t item;
  dist_res_t dres;

  logic matched;
  logic [3:0] res_idx;
  coord_t res_bx, res_by;
  dist_t res_d;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign func      = in_tuser;
  assign in_x      = in_tdata[COORD_W-1:0];
  assign in_y      = in_tdata[2*COORD_W-1:COORD_W];
  assign is_load   = in_acc && (func == FUNC_LOAD);
  assign has_room  = (count_r < CNT_W'(MAX_POINTS));
  assign out_free  = !out_valid_r || out_tready;

  // ring of cells: cell i takes its point from cell i+1 while scanning
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign cell_ctl[i].rotate = (state_r == ST_SCAN);
    assign cell_ctl[i].load   = is_load && has_room &&
                                (count_r[IDX_W-1:0] == IDX_W'(i));
    nnp_cell u_cell (
      .clk  (clk),
      .ctl  (cell_ctl[i]),
      .wr_x (in_x),
      .wr_y (in_y),
      .nb_x (cell_x[(i + 1) % MAX_POINTS]),
      .nb_y (cell_y[(i + 1) % MAX_POINTS]),
      .x    (cell_x[i]),
      .y    (cell_y[i])
    );
  end

  always_comb begin
    item.valid = (state_r == ST_SCAN) && (step_r < count_r);
    item.last  = (state_r == ST_SCAN) && (step_r == CNT_W'(MAX_POINTS - 1));
    item.idx   = step_r[IDX_W-1:0];
    item.px    = cell_x[0];
    item.py    = cell_y[0];
  end

  nnp_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .cx    (qx_r),
    .cy    (qy_r),
    .ox    (offset_x_r),
    .oy    (offset_y_r),
    .res   (dres)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (func)
            FUNC_CLEAR: begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
            end
            FUNC_LOAD: begin
              if (has_room) count_nxt = count_r + CNT_W'(1);
              else dropped_nxt = 1'b1;
            end
            FUNC_QUERY: begin
              step_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == CNT_W'(MAX_POINTS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (dres.last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (func == FUNC_QUERY)) begin
      qx_r <= in_x;
      qy_r <= in_y;
    end
  end

  // strict less keeps the lowest index on ties
  assign take_best = dres.valid && (!found_r || (dres.dsq < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_acc && (func == FUNC_QUERY)) begin
      found_r <= 1'b0;
    end else if (take_best) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_d_r   <= dres.dsq;
      best_idx_r <= dres.idx;
      best_x_r   <= dres.px;
      best_y_r   <= dres.py;
    end
  end

  // an empty store reports all best fields as zero
  always_comb begin
    matched = found_r && (best_d_r < threshold_r);
    res_idx = found_r ? 4'(best_idx_r) : 4'd0;
    res_bx  = found_r ? best_x_r : '0;
    res_by  = found_r ? best_y_r : '0;
    res_d   = found_r ? best_d_r : '0;
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= OUT_DATA_W'({dropped_r, res_d, res_by, res_bx, res_idx,
                                 qy_r, qx_r, matched});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      threshold_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_OFFSET_X:  offset_x_r  <= cfg_pwdata[COORD_W-1:0];
        REG_OFFSET_Y:  offset_y_r  <= cfg_pwdata[COORD_W-1:0];
        REG_THRESHOLD: threshold_r <= cfg_pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OFFSET_X:  cfg_prdata = CFG_DATA_W'({offset_x_r});
      REG_OFFSET_Y:  cfg_prdata = CFG_DATA_W'({offset_y_r});
      REG_THRESHOLD: cfg_prdata = CFG_DATA_W'(threshold_r);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

// ----- rtl/nnp_checker.sv -----
// port-level checks for the nearest neighbor pairing block, with its bind
module nnp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [1:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [nnp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import nnp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // a query makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_QUERY) |=> !in_tready)
    else $error("input still ready after a query");

  // clear and load leave the input ready for the next word
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != FUNC_QUERY) |=> in_tready)
    else $error("input not ready after a clear or load");

  // a new result only comes out of a query in progress
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a query");

endmodule

bind nearest_neighbor_pairing nnp_checker u_nnp_checker (.*);
